>>> rtl/core/drw_pkg.sv
// ----------------------------------------------------------------------------
// drw_pkg
// Shared types and constants for the DNS record walker.
// ----------------------------------------------------------------------------
package drw_pkg;

  localparam int unsigned HeaderBytes = 12;
  localparam logic [7:0]  DotChar     = 8'h2E;
  localparam logic [15:0] MaxMsgReset = 16'd512;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_RDATA   = 2'd1,
    KIND_SUMMARY = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERRUN   = 2'd1,
    ERR_TRUNCATED = 2'd2
  } err_e;

  typedef enum logic [5:0] {
    PH_HEADER    = 6'b000001,
    PH_NAME_LEN  = 6'b000010,
    PH_NAME_CHAR = 6'b000100,
    PH_FIELDS    = 6'b001000,
    PH_RDLEN     = 6'b010000,
    PH_RDATA     = 6'b100000
  } phase_e;

  // one queue entry: one or two results caused by one input byte
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic        dot_follows;
    logic [15:0] rec_num;
    logic [15:0] rec_start;
    logic [7:0]  name_len;
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [31:0] ttl;
    logic [15:0] rdlen;
    err_e        err;
  } drw_entry_t;

endpackage

>>> rtl/core/dns_record_walker.sv
// ----------------------------------------------------------------------------
// dns_record_walker
// Streaming DNS message record parser, one message byte per transaction.
// ----------------------------------------------------------------------------
// Takes one byte per cycle. The parser turns each byte into zero, one or two
// results (name characters with dots, RDATA bytes, a per-record summary, or an
// error) in the same cycle and writes them as one entry into a QUEUE_DEPTH
// deep queue; the output register issues one result per cycle while out_stall_i
// is low, so a label byte that closes a label gives two results. in_stall_o
// rises only while the queue is full. The user must write max_message_bytes
// via cfg_we_i while the block is idle, which it does not enforce; its reset value is 512.
module dns_record_walker #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  message_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] record_number_o,
  output logic [15:0] record_start_o,
  output logic [7:0]  name_wire_length_o,
  output logic [15:0] record_type_o,
  output logic [15:0] record_class_o,
  output logic [31:0] time_to_live_o,
  output logic [15:0] rdata_length_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);

  logic                accept;
  logic                push, pop, empty, full;
  drw_pkg::drw_entry_t entry, head, res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  drw_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .accept_i         (accept),
    .message_byte_i   (message_byte_i),
    .end_of_message_i (end_of_message_i),
    .push_o           (push),
    .entry_o          (entry)
  );

  drw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  drw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res),
    .last_o      (last_of_run_o)
  );

  assign result_kind_o      = res.kind;
  assign out_byte_o         = res.out_byte;
  assign record_number_o    = res.rec_num;
  assign record_start_o     = res.rec_start;
  assign name_wire_length_o = res.name_len;
  assign record_type_o      = res.rtype;
  assign record_class_o     = res.rclass;
  assign time_to_live_o     = res.ttl;
  assign rdata_length_o     = res.rdlen;
  assign error_code_o       = res.err;

endmodule

>>> rtl/core/drw_front.sv
// ----------------------------------------------------------------------------
// drw_front
// Byte parser: tracks the record structure and builds result entries.
// ----------------------------------------------------------------------------
module drw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                accept_i,
  input  logic [7:0]          message_byte_i,
  input  logic                end_of_message_i,
  output logic                push_o,
  output drw_pkg::drw_entry_t entry_o
);

  drw_pkg::phase_e phase_q, phase_d;
  logic [15:0] max_q;
  logic [15:0] off_q, off_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] begin_q, begin_d;
  logic [7:0]  label_q, label_d;
  logic [7:0]  nseen_q, nseen_d;
  logic [2:0]  fcnt_q, fcnt_d;
  logic [15:0] type_q, type_d;
  logic [15:0] class_q, class_d;
  logic [31:0] ttl_q, ttl_d;
  logic [15:0] rd_q, rd_d;
  logic        err_q, err_d;

  drw_pkg::drw_entry_t ent;
  logic                emit;
  logic [7:0]          nseen_inc;
  logic [16:0]         off_plus;

  assign nseen_inc = (nseen_q == 8'hFF) ? nseen_q : nseen_q + 8'd1;
  assign off_plus  = {1'b0, off_q} + 17'd1;

  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    cnt_d   = cnt_q;
    begin_d = begin_q;
    label_d = label_q;
    nseen_d = nseen_q;
    fcnt_d  = fcnt_q;
    type_d  = type_q;
    class_d = class_q;
    ttl_d   = ttl_q;
    rd_d    = rd_q;
    err_d   = err_q;
    emit    = 1'b0;
    ent     = '0;

    if (accept_i) begin
      if (err_q) begin
        if (end_of_message_i) begin
          phase_d = drw_pkg::PH_HEADER;
          off_d   = '0;
          cnt_d   = '0;
          begin_d = '0;
          label_d = '0;
          nseen_d = '0;
          fcnt_d  = '0;
          type_d  = '0;
          class_d = '0;
          ttl_d   = '0;
          rd_d    = '0;
          err_d   = 1'b0;
        end
      end else if (off_q >= max_q) begin
        emit          = 1'b1;
        ent.kind      = drw_pkg::KIND_ERROR;
        ent.err       = drw_pkg::ERR_OVERRUN;
        ent.rec_num   = cnt_q;
        ent.rec_start = begin_q;
        if (end_of_message_i) begin
          phase_d = drw_pkg::PH_HEADER;
          off_d   = '0;
          cnt_d   = '0;
          begin_d = '0;
          label_d = '0;
          nseen_d = '0;
          fcnt_d  = '0;
          type_d  = '0;
          class_d = '0;
          ttl_d   = '0;
          rd_d    = '0;
        end else begin
          err_d = 1'b1;
        end
      end else begin
        case (phase_q)
          drw_pkg::PH_NAME_LEN: begin
            if (nseen_q == 8'd0) begin
              begin_d = off_q;
              type_d  = '0;
              class_d = '0;
              ttl_d   = '0;
              rd_d    = '0;
            end
            nseen_d = nseen_inc;
            if (message_byte_i == 8'd0) begin
              if (nseen_q == 8'd0) begin
                emit         = 1'b1;
                ent.kind     = drw_pkg::KIND_CHAR;
                ent.out_byte = drw_pkg::DotChar;
              end
              phase_d = drw_pkg::PH_FIELDS;
              fcnt_d  = '0;
            end else begin
              label_d = message_byte_i;
              phase_d = drw_pkg::PH_NAME_CHAR;
            end
          end
          drw_pkg::PH_NAME_CHAR: begin
            emit         = 1'b1;
            ent.kind     = drw_pkg::KIND_CHAR;
            ent.out_byte = message_byte_i;
            nseen_d      = nseen_inc;
            label_d      = label_q - 8'd1;
            if (label_d == 8'd0) begin
              ent.dot_follows = 1'b1;
              phase_d         = drw_pkg::PH_NAME_LEN;
            end
          end
          drw_pkg::PH_FIELDS: begin
            if (fcnt_q < 3'd2) begin
              type_d = {type_q[7:0], message_byte_i};
            end else if (fcnt_q < 3'd4) begin
              class_d = {class_q[7:0], message_byte_i};
            end else begin
              ttl_d = {ttl_q[23:0], message_byte_i};
            end
            if (cnt_q == 16'd0 && fcnt_q == 3'd3) begin
              emit         = 1'b1;
              ent.kind     = drw_pkg::KIND_SUMMARY;
              ent.name_len = nseen_q;
              ent.rtype    = type_d;
              ent.rclass   = class_d;
              cnt_d        = cnt_q + 16'd1;
              phase_d      = drw_pkg::PH_NAME_LEN;
              nseen_d      = '0;
              label_d      = '0;
            end else if (fcnt_q == 3'd7) begin
              phase_d = drw_pkg::PH_RDLEN;
              fcnt_d  = '0;
            end else begin
              fcnt_d = fcnt_q + 3'd1;
            end
          end
          drw_pkg::PH_RDLEN: begin
            rd_d = {rd_q[7:0], message_byte_i};
            if (fcnt_q == 3'd0) begin
              fcnt_d = 3'd1;
            end else begin
              emit         = 1'b1;
              ent.kind     = drw_pkg::KIND_SUMMARY;
              ent.name_len = nseen_q;
              ent.rtype    = type_q;
              ent.rclass   = class_q;
              ent.ttl      = ttl_q;
              ent.rdlen    = rd_d;
              fcnt_d       = '0;
              if (rd_d == 16'd0) begin
                cnt_d   = cnt_q + 16'd1;
                phase_d = drw_pkg::PH_NAME_LEN;
                nseen_d = '0;
                label_d = '0;
              end else begin
                phase_d = drw_pkg::PH_RDATA;
              end
            end
          end
          drw_pkg::PH_RDATA: begin
            emit         = 1'b1;
            ent.kind     = drw_pkg::KIND_RDATA;
            ent.out_byte = message_byte_i;
            rd_d         = rd_q - 16'd1;
            if (rd_d == 16'd0) begin
              cnt_d   = cnt_q + 16'd1;
              phase_d = drw_pkg::PH_NAME_LEN;
              nseen_d = '0;
              label_d = '0;
            end
          end
          default: begin
            if (off_plus >= 17'(drw_pkg::HeaderBytes)) begin
              phase_d = drw_pkg::PH_NAME_LEN;
              nseen_d = '0;
            end
          end
        endcase
        ent.rec_num   = cnt_q;
        ent.rec_start = begin_d;
        off_d         = off_plus[15:0];

        if (end_of_message_i) begin
          if (!(phase_d == drw_pkg::PH_NAME_LEN && nseen_d == 8'd0)) begin
            emit          = 1'b1;
            ent           = '0;
            ent.kind      = drw_pkg::KIND_ERROR;
            ent.err       = drw_pkg::ERR_TRUNCATED;
            ent.rec_num   = cnt_d;
            ent.rec_start = begin_d;
          end
          phase_d = drw_pkg::PH_HEADER;
          off_d   = '0;
          cnt_d   = '0;
          begin_d = '0;
          label_d = '0;
          nseen_d = '0;
          fcnt_d  = '0;
          type_d  = '0;
          class_d = '0;
          ttl_d   = '0;
          rd_d    = '0;
        end
      end
    end
  end

  assign push_o  = emit;
  assign entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= drw_pkg::PH_HEADER;
      max_q   <= drw_pkg::MaxMsgReset;
      off_q   <= '0;
      cnt_q   <= '0;
      begin_q <= '0;
      label_q <= '0;
      nseen_q <= '0;
      fcnt_q  <= '0;
      type_q  <= '0;
      class_q <= '0;
      ttl_q   <= '0;
      rd_q    <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      off_q   <= off_d;
      cnt_q   <= cnt_d;
      begin_q <= begin_d;
      label_q <= label_d;
      nseen_q <= nseen_d;
      fcnt_q  <= fcnt_d;
      type_q  <= type_d;
      class_q <= class_d;
      ttl_q   <= ttl_d;
      rd_q    <= rd_d;
      err_q   <= err_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // latched overrun swallows everything up to end of message
  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && err_q) |-> !push_o)
    else $error("result produced while overrun latched");

  a_eom_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_message_i) |=> (off_q == 16'd0 && !err_q))
    else $error("parse state not cleared after end of message");
`endif

endmodule

>>> rtl/core/drw_queue.sv
// ----------------------------------------------------------------------------
// drw_queue
// Small FIFO of result entries between parser and output stage.
// ----------------------------------------------------------------------------
module drw_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  drw_pkg::drw_entry_t entry_i,
  input  logic                pop_i,
  output drw_pkg::drw_entry_t head_o,
  output logic                empty_o,
  output logic                full_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  drw_pkg::drw_entry_t mem [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign head_o  = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");
`endif

endmodule

>>> rtl/core/drw_back.sv
// ----------------------------------------------------------------------------
// drw_back
// Output stage: unpacks queue entries into single registered results.
// ----------------------------------------------------------------------------
module drw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  drw_pkg::drw_entry_t head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output drw_pkg::drw_entry_t out_o,
  output logic                last_o
);

  logic                out_valid_q, out_valid_d;
  logic                sub_q, sub_d;
  drw_pkg::drw_entry_t out_q, out_d;
  logic                last_q;
  logic                load;

  assign load = (!out_valid_q || !out_stall_i) && !empty_i;
  assign pop_o = load && (sub_q || !head_i.dot_follows);

  always_comb begin
    out_valid_d = out_valid_q;
    sub_d       = sub_q;
    out_d       = head_i;
    if (sub_q) begin
      out_d.out_byte = drw_pkg::DotChar;
    end
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = !empty_i;
    end
    if (load) begin
      sub_d = head_i.dot_follows && !sub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q  <= out_d;
      last_q <= sub_q || !head_i.dot_follows;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  // second half of a two-result entry must still be at the queue head
  a_sub_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (!empty_i && head_i.dot_follows))
    else $error("pending dot without queue entry");
`endif

endmodule

>>> tb/tb_dns_record_walker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dns_record_walker
// Self-checking bench for the streaming DNS record walker. A short table of
// hand-picked bytes opens the run, then randomly built messages follow:
// mostly well-formed headers, questions and resource records, with some noise
// and some cut short. Every accepted byte goes through a local parser model;
// each result transaction is checked against the oldest expected one. Both
// handshakes idle in short random bursts, and the buffer size is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_dns_record_walker;

  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned QUIET_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    drw_pkg::kind_e kind;
    logic [7:0]     out_byte;
    logic [15:0]    rec_num;
    logic [15:0]    rec_start;
    logic [7:0]     name_len;
    logic [15:0]    rtype;
    logic [15:0]    rclass;
    logic [31:0]    ttl;
    logic [15:0]    rdlen;
    drw_pkg::err_e  err;
    logic           last;
  } walk_result_t;

  typedef struct packed {
    bit           cfg;
    logic [15:0]  max_val;
    logic [7:0]   b;
    logic         eom;
    bit           typed;
    walk_result_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  message_byte_i = '0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  out_byte_o;
  logic [15:0] record_number_o;
  logic [15:0] record_start_o;
  logic [7:0]  name_wire_length_o;
  logic [15:0] record_type_o;
  logic [15:0] record_class_o;
  logic [31:0] time_to_live_o;
  logic [15:0] rdata_length_o;
  logic [1:0]  error_code_o;
  logic        last_of_run_o;

  dns_record_walker dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .message_byte_i     (message_byte_i),
    .end_of_message_i   (end_of_message_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_kind_o      (result_kind_o),
    .out_byte_o         (out_byte_o),
    .record_number_o    (record_number_o),
    .record_start_o     (record_start_o),
    .name_wire_length_o (name_wire_length_o),
    .record_type_o      (record_type_o),
    .record_class_o     (record_class_o),
    .time_to_live_o     (time_to_live_o),
    .rdata_length_o     (rdata_length_o),
    .error_code_o       (error_code_o),
    .last_of_run_o      (last_of_run_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // parser model state
  logic [15:0]     max_len;
  drw_pkg::phase_e ph;
  logic [15:0]     offs;
  logic [15:0]     rec_cnt;
  logic [15:0]     rec_beg;
  logic [7:0]      lab_left;
  logic [7:0]      name_seen;
  logic [2:0]      fld_cnt;
  logic [15:0]     type_acc;
  logic [15:0]     class_acc;
  logic [31:0]     ttl_acc;
  logic [15:0]     rd_left;
  bit              latched;

  walk_result_t byte_results[$];
  walk_result_t due_results[$];
  dir_row_t     directed_rows[$];
  logic [7:0]   msg_bytes[$];

  bit          idle_on = 1'b1;
  int unsigned walked_items = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;

  function automatic string show(walk_result_t r);
    return {$sformatf("kind %0d byte %02h rec %0d start %0d nlen %0d type %04h ",
                      r.kind, r.out_byte, r.rec_num, r.rec_start, r.name_len, r.rtype),
            $sformatf("class %04h ttl %08h rdlen %0d err %0d last %0b",
                      r.rclass, r.ttl, r.rdlen, r.err, r.last)};
  endfunction

  function automatic walk_result_t mk(drw_pkg::kind_e k, logic [7:0] ob);
    walk_result_t r;
    r = '0;
    r.kind      = k;
    r.out_byte  = ob;
    r.rec_num   = rec_cnt;
    r.rec_start = rec_beg;
    return r;
  endfunction

  function automatic walk_result_t mk_summary(bit rr);
    walk_result_t r;
    r = mk(drw_pkg::KIND_SUMMARY, 8'h00);
    r.name_len = name_seen;
    r.rtype    = type_acc;
    r.rclass   = class_acc;
    r.ttl      = rr ? ttl_acc : 32'h0;
    r.rdlen    = rr ? rd_left : 16'h0;
    return r;
  endfunction

  function automatic void clear_walk();
    ph        = drw_pkg::PH_HEADER;
    offs      = '0;
    rec_cnt   = '0;
    rec_beg   = '0;
    lab_left  = '0;
    name_seen = '0;
    fld_cnt   = '0;
    type_acc  = '0;
    class_acc = '0;
    ttl_acc   = '0;
    rd_left   = '0;
    latched   = 1'b0;
  endfunction

  function automatic void end_rec();
    rec_cnt   = rec_cnt + 16'd1;
    ph        = drw_pkg::PH_NAME_LEN;
    name_seen = '0;
    lab_left  = '0;
  endfunction

  function automatic void bump_name();
    if (name_seen != 8'hFF) name_seen = name_seen + 8'd1;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eom);
    walk_result_t r;
    byte_results.delete();
    walked_items++;
    if (latched) begin
      if (eom) clear_walk();
    end else if (offs >= max_len) begin
      r = mk(drw_pkg::KIND_ERROR, 8'h00);
      r.err  = drw_pkg::ERR_OVERRUN;
      r.last = 1'b1;
      byte_results.push_back(r);
      if (eom) clear_walk();
      else latched = 1'b1;
    end else begin
      case (ph)
        drw_pkg::PH_NAME_LEN: begin
          if (name_seen == 0) begin
            rec_beg   = offs;
            type_acc  = '0;
            class_acc = '0;
            ttl_acc   = '0;
            rd_left   = '0;
          end
          if (b == 8'h00) begin
            if (name_seen == 0) begin
              byte_results.push_back(mk(drw_pkg::KIND_CHAR, drw_pkg::DotChar));
            end
            bump_name();
            ph      = drw_pkg::PH_FIELDS;
            fld_cnt = '0;
          end else begin
            bump_name();
            lab_left = b;
            ph       = drw_pkg::PH_NAME_CHAR;
          end
        end
        drw_pkg::PH_NAME_CHAR: begin
          byte_results.push_back(mk(drw_pkg::KIND_CHAR, b));
          bump_name();
          lab_left = lab_left - 8'd1;
          if (lab_left == 0) begin
            byte_results.push_back(mk(drw_pkg::KIND_CHAR, drw_pkg::DotChar));
            ph = drw_pkg::PH_NAME_LEN;
          end
        end
        drw_pkg::PH_FIELDS: begin
          if (fld_cnt < 2) type_acc = {type_acc[7:0], b};
          else if (fld_cnt < 4) class_acc = {class_acc[7:0], b};
          else ttl_acc = {ttl_acc[23:0], b};
          if (rec_cnt == 0 && fld_cnt == 3) begin
            byte_results.push_back(mk_summary(1'b0));
            end_rec();
          end else if (fld_cnt >= 7) begin
            ph      = drw_pkg::PH_RDLEN;
            fld_cnt = '0;
          end else begin
            fld_cnt = fld_cnt + 3'd1;
          end
        end
        drw_pkg::PH_RDLEN: begin
          rd_left = {rd_left[7:0], b};
          if (fld_cnt == 0) begin
            fld_cnt = 3'd1;
          end else begin
            byte_results.push_back(mk_summary(1'b1));
            fld_cnt = '0;
            if (rd_left == 0) end_rec();
            else ph = drw_pkg::PH_RDATA;
          end
        end
        drw_pkg::PH_RDATA: begin
          byte_results.push_back(mk(drw_pkg::KIND_RDATA, b));
          rd_left = rd_left - 16'd1;
          if (rd_left == 0) end_rec();
        end
        default: begin
          if (32'(offs) + 1 >= drw_pkg::HeaderBytes) begin
            ph        = drw_pkg::PH_NAME_LEN;
            name_seen = '0;
          end
        end
      endcase
      offs = offs + 16'd1;
      if (eom && !(ph == drw_pkg::PH_NAME_LEN && name_seen == 0)) begin
        byte_results.delete();
        r = mk(drw_pkg::KIND_ERROR, 8'h00);
        r.err = drw_pkg::ERR_TRUNCATED;
        byte_results.push_back(r);
      end
      if (byte_results.size() > 0) begin
        r = byte_results.pop_back();
        r.last = 1'b1;
        byte_results.push_back(r);
      end
      if (eom) clear_walk();
    end
  endfunction

  // ---- directed table ----
  function automatic walk_result_t lone(drw_pkg::kind_e k, logic [7:0] ob,
                                        logic [15:0] start, drw_pkg::err_e e);
    walk_result_t r;
    r = '0;
    r.kind      = k;
    r.out_byte  = ob;
    r.rec_start = start;
    r.err       = e;
    r.last      = 1'b1;
    return r;
  endfunction

  function automatic void add_step(logic [7:0] b, logic eom, bit typed,
                                   walk_result_t want);
    dir_row_t row;
    row       = '0;
    row.b     = b;
    row.eom   = eom;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_header();
    int unsigned i;
    for (i = 0; i < drw_pkg::HeaderBytes; i++) begin
      add_step(i[0] ? 8'hFF : 8'h00, 1'b0, 1'b0, '0);
    end
  endfunction

  function automatic void add_cfg(logic [15:0] v);
    dir_row_t row;
    row         = '0;
    row.cfg     = 1'b1;
    row.max_val = v;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed();
    int unsigned i;
    logic [7:0] rr_fields[10];
    rr_fields = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01};
    // cut inside the header straight after reset
    add_step(8'h00, 1'b1, 1'b1,
             lone(drw_pkg::KIND_ERROR, 8'h00, 16'd0, drw_pkg::ERR_TRUNCATED));
    // root-name question, then one record with extreme fields and one RDATA byte
    add_header();
    add_step(8'h00, 1'b0, 1'b1,
             lone(drw_pkg::KIND_CHAR, drw_pkg::DotChar, 16'd12, drw_pkg::ERR_NONE));
    add_step(8'hFF, 1'b0, 1'b0, '0);
    add_step(8'hFF, 1'b0, 1'b0, '0);
    add_step(8'h00, 1'b0, 1'b0, '0);
    add_step(8'h00, 1'b0, 1'b0, '0);
    add_step(8'h01, 1'b0, 1'b0, '0);
    add_step(8'hFF, 1'b0, 1'b0, '0);
    add_step(8'h00, 1'b0, 1'b0, '0);
    for (i = 0; i < 10; i++) add_step(rr_fields[i], 1'b0, 1'b0, '0);
    add_step(8'hAB, 1'b1, 1'b0, '0);
    // message ends inside a label
    add_header();
    add_step(8'h03, 1'b0, 1'b0, '0);
    add_step(8'h61, 1'b1, 1'b1,
             lone(drw_pkg::KIND_ERROR, 8'h00, 16'd12, drw_pkg::ERR_TRUNCATED));
    // smallest buffer: first byte past the header overruns, the rest is dropped
    add_cfg(16'd12);
    add_header();
    add_step(8'h00, 1'b0, 1'b1,
             lone(drw_pkg::KIND_ERROR, 8'h00, 16'd0, drw_pkg::ERR_OVERRUN));
    add_step(8'h55, 1'b0, 1'b0, '0);
    add_step(8'hAA, 1'b1, 1'b0, '0);
  endfunction

  // ---- random message builder ----
  function automatic void push_rand(int unsigned count);
    logic [7:0] b;
    repeat (count) begin
      b = 8'($urandom_range(0, 255));
      msg_bytes.push_back(b);
    end
  endfunction

  function automatic void push_name(bit long_name);
    int unsigned labels;
    int unsigned len;
    // two long labels always run the name length past 255
    labels = long_name ? 2 : $urandom_range(0, 3);
    repeat (labels) begin
      if (long_name) len = $urandom_range(128, 160);
      else if ($urandom_range(0, 49) == 0) len = 255;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 63);
      else len = $urandom_range(1, 8);
      msg_bytes.push_back(8'(len));
      push_rand(len);
    end
    msg_bytes.push_back(8'h00);
  endfunction

  function automatic void push_fields(bit rr);
    int unsigned len;
    push_rand(rr ? 8 : 4);
    if (rr) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 6);
      msg_bytes.push_back(8'(len >> 8));
      msg_bytes.push_back(8'(len));
      push_rand(len);
    end
  endfunction

  // ---- drivers ----
  task automatic send_byte(input logic [7:0] b, input logic eom, input bit typed,
                           input walk_result_t want);
    int unsigned i;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    message_byte_i   <= b;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_byte(b, eom);
    if (typed) due_results.push_back(want);
    else for (i = 0; i < byte_results.size(); i++) due_results.push_back(byte_results[i]);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_max_len(input logic [15:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_len = v;
  endtask

  task automatic walk_message(input bit long_name);
    int unsigned mode;
    int unsigned cut;
    int unsigned i;
    msg_bytes.delete();
    mode = $urandom_range(0, 9);
    push_rand(drw_pkg::HeaderBytes);
    if (mode == 0) begin
      push_rand($urandom_range(1, 40));
    end else begin
      push_name(long_name);
      push_fields(1'b0);
      repeat ($urandom_range(0, 2)) begin
        push_name(1'b0);
        push_fields(1'b1);
      end
      if (mode == 1) begin
        cut = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
    end
    for (i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
  endtask

  // ---- receiver back-pressure ----
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left  = $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---- result checker ----
  always @(posedge clk_i) begin
    walk_result_t got;
    walk_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind      = drw_pkg::kind_e'(result_kind_o);
      got.out_byte  = out_byte_o;
      got.rec_num   = record_number_o;
      got.rec_start = record_start_o;
      got.name_len  = name_wire_length_o;
      got.rtype     = record_type_o;
      got.rclass    = record_class_o;
      got.ttl       = time_to_live_o;
      got.rdlen     = rdata_length_o;
      got.err       = drw_pkg::err_e'(error_code_o);
      got.last      = last_of_run_o;
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("unexpected transaction: %s", show(got));
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---- main sequence ----
  initial begin
    int unsigned p;
    int unsigned target;
    int unsigned phase_items[6];
    logic [15:0] phase_max;
    dir_row_t row;
    phase_items = '{250, 30, 20, 10, 20, 30};
    max_len = drw_pkg::MaxMsgReset;
    clear_walk();
    build_directed();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.cfg) set_max_len(row.max_val);
      else send_byte(row.b, row.eom, row.typed, row.want);
    end

    for (p = 0; p < 6; p++) begin
      case (p)
        0, 5:    phase_max = 16'hFFFF;
        1:       phase_max = drw_pkg::MaxMsgReset;
        2:       phase_max = 16'($urandom_range(13, 90));
        3:       phase_max = 16'(drw_pkg::HeaderBytes);
        default: phase_max = 16'($urandom_range(91, 2000));
      endcase
      set_max_len(phase_max);
      idle_on = (p != 5);
      target = walked_items + phase_items[p];
      walk_message(p == 0);
      while (walked_items < target) begin
        walk_message(1'b0);
        if ($urandom_range(0, 9) == 0) settle();
      end
    end

    settle();
    if (fail_count == 0 && due_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
